FILE: rtl/sitda_pkg.sv
// Shared constants, types and state encodings for the decimal text converter.
`timescale 1ns / 1ps

package sitda_pkg;

    // Width of the two's-complement input word.
    localparam int VALUE_BITS = 32;

    // Decimal digits needed for any magnitude up to 2^VALUE_BITS - 1
    // (1233 / 4096 approximates log10(2) from below over the supported range).
    localparam int DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_W  = DIGITS * 4;
    localparam int CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int TOP_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CODE_W = 6;

    localparam logic [CODE_W-1:0] CODE_MINUS = 6'd45;
    localparam logic [CODE_W-1:0] CODE_ZERO  = 6'd48;

    // Classified item passed from the front queue to the converter.
    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } item_t;

    // Converted number passed from the converter to the character emitter.
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
        logic [TOP_W-1:0] top;
    } conv_res_t;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_SHIFT,
        CV_FIND,
        CV_HOLD
    } conv_state_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SIGN,
        EM_DIGIT
    } emit_state_t;

endpackage

FILE: rtl/sitda_front.sv
// Input side: sign and magnitude classification followed by a two-entry queue.
`timescale 1ns / 1ps

module sitda_front
    import sitda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  item_valid,
    output item_t                 item,
    input  logic                  item_take
);

    item_t       q_mem [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        push_acc;
    logic        pop_acc;
    item_t       in_item;

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_mem[rd_ptr_reg];
    assign push_acc   = push && !full;
    assign pop_acc    = item_take && item_valid;

    // The magnitude of the most negative value wraps to itself, which is
    // exactly its unsigned magnitude.
    always_comb
    begin
        in_item.neg = value[VALUE_BITS-1];
        in_item.mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
    end

    always_comb
    begin
        wr_ptr_next = push_acc ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_acc ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_acc && !pop_acc)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop_acc && !push_acc)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/sitda_conv.sv
// Binary to BCD converter: shift-add-3 over one input bit per cycle.
`timescale 1ns / 1ps

module sitda_conv
    import sitda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  item_t     item,
    output logic      item_take,
    output logic      res_valid,
    output conv_res_t res,
    input  logic      res_take
);

    conv_state_t           state_reg;
    conv_state_t           state_next;
    logic [VALUE_BITS-1:0] mag_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_adj;
    logic [CNT_W-1:0]      cnt_reg;
    logic [TOP_W-1:0]      top_reg;
    logic [TOP_W-1:0]      top_calc;
    logic                  neg_reg;
    logic                  shift_en;
    logic                  find_en;

    // Add three to every digit of five or more before the shift.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                (bcd_reg[i*4 +: 4] + 4'd3) : bcd_reg[i*4 +: 4];
        end
    end

    // Position of the most significant nonzero digit; zero gives position 0.
    always_comb
    begin
        top_calc = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
            begin
                top_calc = TOP_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CV_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = CV_SHIFT;
                end
            end
            CV_SHIFT:
            begin
                if (cnt_reg == CNT_W'(VALUE_BITS - 1))
                begin
                    state_next = CV_FIND;
                end
            end
            CV_FIND:
            begin
                state_next = CV_HOLD;
            end
            CV_HOLD:
            begin
                if (res_take)
                begin
                    state_next = CV_IDLE;
                end
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_take = (state_reg == CV_IDLE) && item_valid;
        shift_en  = (state_reg == CV_SHIFT);
        find_en   = (state_reg == CV_FIND);
        res_valid = (state_reg == CV_HOLD);
        res.neg   = neg_reg;
        res.bcd   = bcd_reg;
        res.top   = top_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            mag_reg <= item.mag;
            neg_reg <= item.neg;
            bcd_reg <= '0;
            cnt_reg <= '0;
        end
        else if (shift_en)
        begin
            bcd_reg <= {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
            mag_reg <= {mag_reg[VALUE_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (find_en)
        begin
            top_reg <= top_calc;
        end
    end

endmodule

FILE: rtl/sitda_emit.sv
// Character sequencer with a two-entry character queue toward the output.
`timescale 1ns / 1ps

module sitda_emit
    import sitda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  conv_res_t         res,
    output logic              res_take,
    output logic              empty,
    input  logic              pop,
    output logic [CODE_W-1:0] char_code,
    output logic              last
);

    emit_state_t       state_reg;
    emit_state_t       state_next;
    logic [BCD_W-1:0]  bcd_reg;
    logic [TOP_W-1:0]  ptr_reg;
    logic              gen;
    logic [CODE_W-1:0] gen_code;
    logic              gen_last;
    logic [3:0]        cur_digit;

    logic [CODE_W-1:0] q_code [2];
    logic              q_last [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic              q_full;
    logic              pop_acc;

    assign q_full    = (cnt_reg == 2'd2);
    assign empty     = (cnt_reg == 2'd0);
    assign char_code = q_code[rd_ptr_reg];
    assign last      = q_last[rd_ptr_reg];
    assign pop_acc   = pop && !empty;
    assign cur_digit = bcd_reg[ptr_reg*4 +: 4];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (res_valid)
                begin
                    state_next = res.neg ? EM_SIGN : EM_DIGIT;
                end
            end
            EM_SIGN:
            begin
                if (gen)
                begin
                    state_next = EM_DIGIT;
                end
            end
            EM_DIGIT:
            begin
                if (gen && (ptr_reg == '0))
                begin
                    state_next = EM_IDLE;
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_take = (state_reg == EM_IDLE) && res_valid;
        gen      = ((state_reg == EM_SIGN) || (state_reg == EM_DIGIT)) && !q_full;
        if (state_reg == EM_SIGN)
        begin
            gen_code = CODE_MINUS;
            gen_last = 1'b0;
        end
        else
        begin
            gen_code = CODE_ZERO + {2'b00, cur_digit};
            gen_last = (ptr_reg == '0);
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (gen && !pop_acc)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop_acc && !gen)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= EM_IDLE;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (gen)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop_acc)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            bcd_reg <= res.bcd;
            ptr_reg <= res.top;
        end
        else if (gen && (state_reg == EM_DIGIT) && (ptr_reg != '0))
        begin
            ptr_reg <= ptr_reg - 1'b1;
        end
        if (gen)
        begin
            q_code[wr_ptr_reg] <= gen_code;
            q_last[wr_ptr_reg] <= gen_last;
        end
    end

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII text converter.
`timescale 1ns / 1ps

// This block turns each 32-bit two's-complement integer into its decimal text,
// delivered as ASCII codes one character per output transaction, most
// significant character first: a minus sign (45) for negative values, then
// the digits (48 to 57), with last set on the final digit. Zero gives the
// single character '0', and the most negative value is converted through its
// unsigned magnitude. Both sides behave as queues: write with push while full
// is low, and read the oldest character while empty is low, taking it with
// pop. A small input queue classifies each number into sign and magnitude;
// the converter then runs a shift-add-3 binary to BCD pass, one input bit per
// cycle, and the emitter walks the digits out through a two-entry output
// queue while the converter already works on the next number. The converter
// is the pacing unit: each number passes through a load step, a shift step
// per input bit, a step to locate the leading digit and a handoff step.
// A number emits at most 11 characters, one per cycle while the output
// queue has room. Nothing is kept from one number to the next.

module signed_int_to_decimal_ascii
    import sitda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  empty,
    input  logic                  pop,
    output logic [CODE_W-1:0]     char_code,
    output logic                  last
);

    // Handoff from the input queue to the converter.
    logic      item_valid;
    item_t     item;
    logic      item_take;

    // Handoff from the converter to the character emitter.
    logic      res_valid;
    conv_res_t res;
    logic      res_take;

    sitda_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .value      (value),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    sitda_conv u_conv
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take)
    );

    sitda_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .empty     (empty),
        .pop       (pop),
        .char_code (char_code),
        .last      (last)
    );

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 1ps

module tb_top
    import sitda_pkg::*;
();

    // The run stops with a failure if it ever gets this far. A correct run,
    // with receiver stalls on each of up to 11 characters per number, ends
    // well before this bound.
    localparam int CYCLE_LIMIT = 1_000_000;

    // Cycles allowed after the last expected character, so that any stray
    // extra character still has time to come out and be flagged.
    localparam int DRAIN_CYCLES = 3 * (VALUE_BITS + 3);

    localparam int RANDOM_NUMBERS = 500;
    localparam int MAX_DIGITS = 24;
    localparam int MAX_SHOWN = 10;
    localparam logic [VALUE_BITS-1:0] RADIX = 10;

    // One character of the expected decimal text.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } text_char_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic [VALUE_BITS-1:0] value = '0;
    logic                  pop = 1'b0;
    logic                  full;
    logic                  empty;
    logic [CODE_W-1:0]     char_code;
    logic                  last;

    // Characters that the accepted numbers are still owed, oldest first.
    text_char_t pending_chars[$];

    int mismatches = 0;
    int cycles = 0;

    // Sender burst bookkeeping: numbers left in the current burst.
    int burst_left = 0;

    // Receiver stall pattern state.
    int         pop_mode = 0;
    int         pop_mode_left = 0;
    logic [7:0] pop_pattern = 8'hFF;
    int         pop_phase = 0;

    signed_int_to_decimal_ascii i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value     (value),
        .empty     (empty),
        .pop       (pop),
        .char_code (char_code),
        .last      (last)
    );

    always #4 clk = ~clk;

    // Global watchdog: counts every cycle and ends a run that hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d characters still expected",
                     cycles, pending_chars.size());
            $display("[signed_int_to_decimal_ascii] ERROR");
            $finish;
        end
    end

    // Works out the decimal text of one number and appends it to the queue of
    // expected characters. The magnitude of a negative number is taken as an
    // unsigned quantity of the full width, so the most negative value works.
    function automatic void predict_chars(input logic [VALUE_BITS-1:0] v);
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
        int                    digit [0:MAX_DIGITS-1];
        int                    nd;
        int                    i;
        text_char_t            c;
        neg = v[VALUE_BITS-1];
        mag = neg ? (~v + 1'b1) : v;
        // Digits come out least significant first; zero still yields one.
        digit[0] = int'(mag % RADIX);
        mag = mag / RADIX;
        nd = 1;
        while (mag != 0)
        begin
            digit[nd] = int'(mag % RADIX);
            mag = mag / RADIX;
            nd++;
        end
        if (neg)
        begin
            c.code = CODE_MINUS;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        for (i = nd - 1; i >= 0; i--)
        begin
            c.code = CODE_ZERO + CODE_W'(digit[i]);
            c.last = (i == 0);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic logic [63:0] pow10(input int k);
        logic [63:0] p;
        int          i;
        p = 1;
        for (i = 0; i < k; i++)
            p = p * 10;
        return p;
    endfunction

    // Random number with a spread of digit counts. Plain 32-bit random values
    // almost always have nine or ten digits, so shorter magnitudes and the edges
    // around powers of ten are mixed in on purpose.
    function automatic logic [VALUE_BITS-1:0] random_number();
        logic [63:0]           m;
        logic [VALUE_BITS-1:0] r;
        int                    k;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1:
            begin
                k = $urandom_range(1, 9);
                m = 64'($urandom_range(0, 32'(pow10(k) - 1)));
            end
            2:
            begin
                k = $urandom_range(0, 9);
                m = pow10(k) + $urandom_range(0, 2) - 1;
            end
            default: m = 64'($urandom_range(0, 20));
        endcase
        r = m[VALUE_BITS-1:0];
        if ($urandom_range(0, 1) == 1)
            r = -r;
        return r;
    endfunction

    // Offers one number to the block and holds it until the block accepts the
    // transaction. The push stays high across back-to-back numbers of a burst;
    // at the end of a burst the sender goes quiet for a random gap, which
    // sometimes is zero so that long unbroken stretches also occur.
    task automatic push_number(input logic [VALUE_BITS-1:0] v);
        int gap;
        @(negedge clk);
        push <= 1'b1;
        value <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_chars(v);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                @(negedge clk);
                push <= 1'b0;
                // Junk on the data lines while push is low must be ignored.
                value <= $urandom;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Zero is the one number with no nonzero digit; its single digit comes from
    // the do-at-least-once digit loop.
    task automatic test_zero();
        push_number('0);
    endtask

    // Largest and most negative values, plus edges where the digit count or
    // the sign changes.
    task automatic test_extremes();
        push_number({1'b0, {(VALUE_BITS-1){1'b1}}});
        push_number({1'b1, {(VALUE_BITS-1){1'b0}}});
        push_number({1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1});
        push_number({1'b0, {(VALUE_BITS-2){1'b1}}, 1'b0});
        push_number(VALUE_BITS'(1));
        push_number('1);
        push_number(VALUE_BITS'(9));
        push_number(VALUE_BITS'(10));
        push_number(-VALUE_BITS'(10));
        push_number(VALUE_BITS'(99));
        push_number(VALUE_BITS'(100));
        push_number(VALUE_BITS'(999_999_999));
        push_number(VALUE_BITS'(1_000_000_000));
        push_number(-VALUE_BITS'(999_999_999));
        push_number(-VALUE_BITS'(1_000_000_000));
    endtask

    // Together these two numbers produce every digit character.
    task automatic test_all_digits();
        push_number(VALUE_BITS'(1_234_567_890));
        push_number(-VALUE_BITS'(987_654_321));
    endtask

    task automatic test_random_numbers();
        int n;
        for (n = 0; n < RANDOM_NUMBERS; n++)
            push_number(random_number());
    endtask

    // The receiver switches between stall modes at random: always ready,
    // coin flip, a repeating pattern from a random byte, and long stalls.
    always @(negedge clk)
    begin
        if (pop_mode_left == 0)
        begin
            pop_mode = $urandom_range(0, 3);
            pop_mode_left = $urandom_range(40, 300);
            pop_pattern = 8'($urandom);
        end
        else
        begin
            pop_mode_left--;
        end
        pop_phase = (pop_phase + 1) % 8;
        case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 1) == 1);
            2: pop <= pop_pattern[pop_phase];
            default: pop <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Every character the receiver takes is compared with the oldest one that
    // is still owed. A character with nothing owed is a failure too.
    always @(posedge clk)
    begin
        text_char_t exp_c;
        if (rst_n && pop && !empty)
        begin
            if (pending_chars.size() == 0)
            begin
                if (mismatches < MAX_SHOWN)
                    $display("Unexpected character: code %0d last %0b",
                             char_code, last);
                mismatches++;
            end
            else
            begin
                exp_c = pending_chars.pop_front();
                if (char_code !== exp_c.code || last !== exp_c.last)
                begin
                    if (mismatches < MAX_SHOWN)
                        $display("Mismatch: expected code %0d last %0b, got code %0d last %0b",
                                 exp_c.code, exp_c.last, char_code, last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        // Reset is held from time zero and released on a
        // falling edge, clear of the rising edge where the block samples.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_zero();
        test_extremes();
        test_all_digits();
        test_random_numbers();

        @(negedge clk);
        push <= 1'b0;

        // Every number produces at least one character, so once the queue of
        // owed characters is empty the block should be idle. Some extra
        // cycles still let a stray character show up.
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[signed_int_to_decimal_ascii] OK");
        else
            $display("[signed_int_to_decimal_ascii] ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/sitda_pkg.sv
rtl/sitda_front.sv
rtl/sitda_conv.sv
rtl/sitda_emit.sv
rtl/signed_int_to_decimal_ascii.sv
bench/tb_top.sv
